FILE: src/mts_pkg.sv
// Shared types and constants for the minimum-tracking stack.
package mts_pkg;

    localparam int VALUE_W             = 32;
    localparam int ENTRY_COUNT_W       = 9;
    localparam int DEFAULT_STACK_DEPTH = 256;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_EMPTY_POP  = 2'd1;
    localparam logic [1:0] STATUS_FULL_PUSH  = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_POP_VALUE = -32'sd217;

    typedef struct packed {
        logic                        action;
        logic signed [VALUE_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]   popped_value;
        logic signed [VALUE_W-1:0]   top_value;
        logic signed [VALUE_W-1:0]   min_value;
        logic [ENTRY_COUNT_W-1:0]    entry_count;
        logic                        is_empty;
        logic [1:0]                  status;
    } rsp_t;

endpackage

FILE: src/min_tracking_stack_unit.sv
// Top level of the minimum-tracking stack: control, top-of-stack registers and two memories.
//
// A bounded LIFO stack of signed 32-bit values that also reports the smallest value held.
// Every request (push or pop) produces exactly one response. The current top of both the
// value stack and the minimum stack sit in registers, so a push, a pop on an empty stack and
// a push on a full stack take one cycle. A successful pop takes two cycles: the entry below
// the top must be read back from the value memory (and, when the minimum is popped, from the
// minimum memory), and those memories have a one-cycle read latency. A new request is taken
// while the previous response is being taken by the consumer. No clearing pass is needed
// after reset; only entries below the current counts are ever read.
module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mts_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mts_pkg::rsp_t rsp
);

    import mts_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                    state_reg,      state_next;
    logic [CNT_W-1:0]          value_count_reg, value_count_next;
    logic [CNT_W-1:0]          min_count_reg,  min_count_next;
    logic signed [VALUE_W-1:0] top_reg,        top_next;
    logic signed [VALUE_W-1:0] min_top_reg,    min_top_next;
    logic signed [VALUE_W-1:0] popped_reg,     popped_next;
    logic                      min_pop_reg,    min_pop_next;
    logic                      rsp_valid_reg,  rsp_valid_next;
    rsp_t                      rsp_reg,        rsp_next;

    logic                      accept;
    logic                      is_full;
    logic                      take_min;
    logic [CNT_W-1:0]          value_cnt_m2;
    logic [CNT_W-1:0]          min_cnt_m2;

    logic                      val_wr_en;
    logic                      min_wr_en;
    logic                      rd_en;
    logic [VALUE_W-1:0]        val_rd_data;
    logic [VALUE_W-1:0]        min_rd_data;

    function automatic rsp_t build_rsp(
        input logic signed [VALUE_W-1:0] popped,
        input logic [1:0]                status,
        input logic signed [VALUE_W-1:0] top,
        input logic signed [VALUE_W-1:0] min_top,
        input logic [CNT_W-1:0]          count
    );
        rsp_t r;
        r.popped_value = popped;
        r.top_value    = top;
        r.min_value    = min_top;
        r.entry_count  = ENTRY_COUNT_W'(count);
        r.is_empty     = (count == '0);
        r.status       = status;
        return r;
    endfunction

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign is_full   = (value_count_reg == CNT_W'(STACK_DEPTH));

    // The minimum stack takes every value that is at most its current top.
    assign take_min  = (min_count_reg == '0) || (req.value <= min_top_reg);

    // The entry just below the top sits two below the count.
    assign value_cnt_m2 = value_count_reg - CNT_W'(2);
    assign min_cnt_m2   = min_count_reg - CNT_W'(2);

    assign val_wr_en = accept && (req.action == ACTION_PUSH) && !is_full;
    assign min_wr_en = val_wr_en && take_min;
    assign rd_en     = accept && (req.action == ACTION_POP) && (value_count_reg != '0);

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_W)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (value_count_reg[ADDR_W-1:0]),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (value_cnt_m2[ADDR_W-1:0]),
        .rd_data (val_rd_data)
    );

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_W)
    ) u_min_ram (
        .clk     (clk),
        .wr_en   (min_wr_en),
        .wr_addr (min_count_reg[ADDR_W-1:0]),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (min_cnt_m2[ADDR_W-1:0]),
        .rd_data (min_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        value_count_next = value_count_reg;
        min_count_next   = min_count_reg;
        top_next         = top_reg;
        min_top_next     = min_top_reg;
        popped_next      = popped_reg;
        min_pop_next     = min_pop_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == ACTION_PUSH)
                    begin
                        if (is_full)
                        begin
                            rsp_next = build_rsp('0, STATUS_FULL_PUSH, top_reg, min_top_reg,
                                                 value_count_reg);
                        end
                        else
                        begin
                            top_next         = req.value;
                            value_count_next = value_count_reg + CNT_W'(1);
                            if (take_min)
                            begin
                                min_top_next   = req.value;
                                min_count_next = min_count_reg + CNT_W'(1);
                            end
                            rsp_next = build_rsp('0, STATUS_OK, top_next, min_top_next,
                                                 value_count_next);
                        end
                        rsp_valid_next = 1'b1;
                    end
                    else if (value_count_reg == '0)
                    begin
                        rsp_next = build_rsp(EMPTY_POP_VALUE, STATUS_EMPTY_POP, top_reg,
                                             min_top_reg, value_count_reg);
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        // The new tops arrive from memory in the next cycle.
                        popped_next      = top_reg;
                        value_count_next = value_count_reg - CNT_W'(1);
                        min_pop_next     = (min_count_reg != '0) && (min_top_reg == top_reg);
                        if (min_pop_next)
                        begin
                            min_count_next = min_count_reg - CNT_W'(1);
                        end
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                top_next = (value_count_reg == '0) ? '0 : $signed(val_rd_data);
                if (min_pop_reg)
                begin
                    min_top_next = (min_count_reg == '0) ? '0 : $signed(min_rd_data);
                end
                rsp_next       = build_rsp(popped_reg, STATUS_OK, top_next, min_top_next,
                                           value_count_reg);
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            value_count_reg <= '0;
            min_count_reg   <= '0;
            top_reg         <= '0;
            min_top_reg     <= '0;
            min_pop_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            value_count_reg <= value_count_next;
            min_count_reg   <= min_count_next;
            top_reg         <= top_next;
            min_top_reg     <= min_top_next;
            min_pop_reg     <= min_pop_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/mts_ram.sv
// Simple dual-port memory: one write port and one registered read port.
module mts_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the minimum-tracking stack: directed table, then random traffic.
module testbench;
    import mts_pkg::*;

    localparam int DEPTH         = DEFAULT_STACK_DEPTH;
    localparam int PLAN_ROWS     = 18;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [VALUE_W-1:0] MAX_S = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] MIN_S = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    min_tracking_stack_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    typedef struct {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
        int                        reps;
        bit                        fixed;
        logic signed [VALUE_W-1:0] e_pop;
        logic signed [VALUE_W-1:0] e_top;
        logic signed [VALUE_W-1:0] e_min;
        int                        e_cnt;
        logic [1:0]                e_st;
    } plan_row_t;

    // Rows without a fixed expectation are checked against the stack predictor.
    plan_row_t plan [PLAN_ROWS] = '{
        '{ACTION_POP,  32'sd0,    1,     1'b1, EMPTY_POP_VALUE, 32'sd0, 32'sd0, 0,
          STATUS_EMPTY_POP},
        '{ACTION_PUSH, MAX_S,     1,     1'b1, 32'sd0, MAX_S, MAX_S, 1, STATUS_OK},
        '{ACTION_PUSH, MIN_S,     1,     1'b1, 32'sd0, MIN_S, MIN_S, 2, STATUS_OK},
        '{ACTION_PUSH, MIN_S,     1,     1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_PUSH, 32'sd0,    1,     1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_PUSH, -32'sd1,   1,     1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_PUSH, MIN_S + 1, 1,     1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_POP,  MAX_S,     4,     1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_POP,  32'sd0,    1,     1'b1, MIN_S, MAX_S, MAX_S, 1, STATUS_OK},
        '{ACTION_POP,  -32'sd1,   1,     1'b1, MAX_S, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_POP,  32'sd0,    1,     1'b1, EMPTY_POP_VALUE, 32'sd0, 32'sd0, 0,
          STATUS_EMPTY_POP},
        '{ACTION_PUSH, -32'sd5,   DEPTH, 1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_PUSH, MAX_S,     1,     1'b1, 32'sd0, -32'sd5, -32'sd5, DEPTH,
          STATUS_FULL_PUSH},
        '{ACTION_PUSH, MIN_S,     1,     1'b1, 32'sd0, -32'sd5, -32'sd5, DEPTH,
          STATUS_FULL_PUSH},
        '{ACTION_POP,  32'sd0,    DEPTH, 1'b0, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK},
        '{ACTION_POP,  MIN_S,     1,     1'b1, EMPTY_POP_VALUE, 32'sd0, 32'sd0, 0,
          STATUS_EMPTY_POP},
        '{ACTION_PUSH, 32'sd0,    1,     1'b1, 32'sd0, 32'sd0, 32'sd0, 1, STATUS_OK},
        '{ACTION_POP,  32'sd0,    1,     1'b1, 32'sd0, 32'sd0, 32'sd0, 0, STATUS_OK}
    };

    // Predictor state: the value stack and the stack of running minimums.
    logic signed [VALUE_W-1:0] held_vals [DEPTH];
    logic signed [VALUE_W-1:0] min_trail [DEPTH];
    int   held_count;
    int   min_depth;
    rsp_t owed_results [$];

    logic fixed_on;
    rsp_t fixed_rsp;
    int   mismatch_count;
    int   accepted_reqs;
    int   idle_cycles;
    int   burst_left;
    int   random_sent;

    function automatic rsp_t make_rsp(logic signed [VALUE_W-1:0] popped,
                                      logic signed [VALUE_W-1:0] top,
                                      logic signed [VALUE_W-1:0] least,
                                      int count, logic [1:0] st);
        rsp_t r;
        r.popped_value = popped;
        r.top_value    = top;
        r.min_value    = least;
        r.entry_count  = ENTRY_COUNT_W'(count);
        r.is_empty     = (count == 0);
        r.status       = st;
        return r;
    endfunction

    function automatic rsp_t stack_step(req_t r);
        logic signed [VALUE_W-1:0] popped;
        logic [1:0]                st;
        popped = '0;
        st     = STATUS_OK;
        if (r.action == ACTION_PUSH)
        begin
            if (held_count >= DEPTH)
                st = STATUS_FULL_PUSH;
            else
            begin
                held_vals[held_count] = r.value;
                held_count++;
                if (min_depth < DEPTH &&
                    (min_depth == 0 || r.value <= min_trail[min_depth - 1]))
                begin
                    min_trail[min_depth] = r.value;
                    min_depth++;
                end
            end
        end
        else if (held_count == 0)
        begin
            popped = EMPTY_POP_VALUE;
            st     = STATUS_EMPTY_POP;
        end
        else
        begin
            popped = held_vals[held_count - 1];
            held_count--;
            if (min_depth > 0 && min_trail[min_depth - 1] == popped)
                min_depth--;
        end
        return make_rsp(popped,
                        held_count > 0 ? held_vals[held_count - 1] : '0,
                        min_depth > 0 ? min_trail[min_depth - 1] : '0,
                        held_count, st);
    endfunction

    // Requests are predicted before responses are checked, so the order inside a step is fixed.
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t predicted;
        if (rst_n && req_valid && req_ready)
        begin
            predicted = stack_step(req);
            owed_results.push_back(fixed_on ? fixed_rsp : predicted);
            accepted_reqs++;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected response: pop=%0d top=%0d min=%0d cnt=%0d empty=%0b st=%0d",
                             rsp.popped_value, rsp.top_value, rsp.min_value,
                             rsp.entry_count, rsp.is_empty, rsp.status);
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp.popped_value !== want.popped_value || rsp.top_value !== want.top_value ||
                    rsp.min_value !== want.min_value || rsp.entry_count !== want.entry_count ||
                    rsp.is_empty !== want.is_empty || rsp.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp pop=%0d top=%0d min=%0d cnt=%0d empty=%0b st=%0d",
                                 want.popped_value, want.top_value, want.min_value,
                                 want.entry_count, want.is_empty, want.status,
                                 "\n          got pop=%0d top=%0d min=%0d cnt=%0d empty=%0b st=%0d",
                                 rsp.popped_value, rsp.top_value, rsp.min_value,
                                 rsp.entry_count, rsp.is_empty, rsp.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Response side: stretches of steady, random and patterned back-pressure, plus two long holds
    // that let the block fill up and stall new requests.
    initial
    begin
        int mode;
        int stretch;
        int holds_done;
        rsp_ready  = 1'b0;
        holds_done = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (holds_done < 2 && accepted_reqs >= (holds_done == 0 ? 700 : 1500))
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(20, 200);
                for (int k = 0; k < stretch; k++)
                begin
                    case (mode)
                        0: rsp_ready <= 1'b1;
                        1: rsp_ready <= 1'($urandom_range(0, 1));
                        2: rsp_ready <= ($urandom_range(0, 4) == 0);
                        default: rsp_ready <= ((k % 5) < 3);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the request has been taken.
    task automatic send_request(input req_t item, input bit has_fixed, input rsp_t fixed_val);
        int gap;
        req_valid <= 1'b1;
        req       <= item;
        fixed_on  <= has_fixed;
        fixed_rsp <= fixed_val;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        @(negedge clk);
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    // Mix of full-range values, small values that repeat often, extremes and values near the minimum.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = int'($urandom_range(0, 16)) - 8;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = MAX_S;
                    1: v = MIN_S;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = (min_depth > 0 ? min_trail[min_depth - 1] : 32'sd0)
                         + int'($urandom_range(0, 2)) - 1;
        endcase
        return v;
    endfunction

    task automatic send_random(input logic act);
        req_t item;
        item.action = act;
        item.value  = (act == ACTION_PUSH) ? pick_value() : $urandom;
        send_request(item, 1'b0, '0);
        random_sent++;
    endtask

    initial
    begin
        req_t item;
        int   mode;
        int   len;
        int   push_pct;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        fixed_on       = 1'b0;
        fixed_rsp      = '0;
        mismatch_count = 0;
        accepted_reqs  = 0;
        idle_cycles    = 0;
        held_count     = 0;
        min_depth      = 0;
        burst_left     = 1;
        random_sent    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            for (int k = 0; k < plan[r].reps; k++)
            begin
                item.action = plan[r].action;
                item.value  = plan[r].value;
                send_request(item, plan[r].fixed,
                             make_rsp(plan[r].e_pop, plan[r].e_top, plan[r].e_min,
                                      plan[r].e_cnt, plan[r].e_st));
            end
        end
        wait_all_answered();

        while (random_sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 8)
            begin
                // Fill to the top, then try to push past it.
                wait_all_answered();
                while (held_count < DEPTH)
                    send_random(ACTION_PUSH);
                repeat ($urandom_range(1, 3)) send_random(ACTION_PUSH);
            end
            else if (mode == 9)
            begin
                while (held_count > 0)
                    send_random(ACTION_POP);
                repeat ($urandom_range(1, 3)) send_random(ACTION_POP);
            end
            else
            begin
                push_pct = (mode < 5) ? 50 : (mode < 7) ? 80 : 20;
                len      = $urandom_range(10, 150);
                repeat (len)
                    send_random(($urandom_range(1, 100) <= push_pct) ? ACTION_PUSH : ACTION_POP);
            end
        end

        wait_all_answered();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
